@@ design/opm_pkg.sv @@
// Shared types and constants for the OpenTherm pair change monitor.
// Used by opm_table and opentherm_pair_change_monitor; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package opm_pkg;

  // Frame tags from the sniffer
  localparam logic [31:0] TAG_MASTER = 32'h15AA_ABCD;
  localparam logic [31:0] TAG_SLAVE  = 32'h14AA_ABCD;

  // Pair table geometry: one entry per message id
  localparam int unsigned ID_W      = 8;
  localparam int unsigned TBL_DEPTH = 1 << ID_W;
  localparam int unsigned PAIR_W    = 64;

  // Result status codes
  localparam logic [2:0] STAT_UNKNOWN   = 3'd0;
  localparam logic [2:0] STAT_PARITY    = 3'd1;
  localparam logic [2:0] STAT_ORDER     = 3'd2;
  localparam logic [2:0] STAT_HELD      = 3'd3;
  localparam logic [2:0] STAT_MISMATCH  = 3'd4;
  localparam logic [2:0] STAT_UNCHANGED = 3'd5;
  localparam logic [2:0] STAT_REPORTED  = 3'd6;

  typedef struct packed {
    logic [31:0] frame_tag;
    logic [31:0] data_word;
  } opm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  msg_id;
    logic [31:0] master_word;
    logic [31:0] slave_word;
    logic [3:0]  master_type;
    logic [3:0]  slave_type;
    logic        spare_nonzero;
  } opm_out_t;

  // Table write request
  typedef struct packed {
    logic              en;
    logic [ID_W-1:0]   idx;
    logic [PAIR_W-1:0] pair;
  } opm_wr_t;

  // Table read request
  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] idx;
  } opm_rd_t;

endpackage

`default_nettype wire

@@ design/opm_table.sv @@
// Last-pair table: 256 x 64-bit synchronous memory plus per-entry valid flops.
// Depends on opm_pkg for geometry and request structs.
`timescale 1ns / 1ps
`default_nettype none

module opm_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire opm_pkg::opm_rd_t            rd,
  input  wire opm_pkg::opm_wr_t            wr,
  output logic [opm_pkg::PAIR_W-1:0]       rd_pair_r,
  output logic                             rd_valid_r
);

  logic [opm_pkg::PAIR_W-1:0]    mem [opm_pkg::TBL_DEPTH];
  logic [opm_pkg::TBL_DEPTH-1:0] valid_r;

  // Write port and registered read port of the pair memory
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.pair;
    end
    if (rd.en) begin
      rd_pair_r <= mem[rd.idx];
    end
  end

  // Valid bits: cleared at reset, set on write, sampled with the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid_r <= valid_r[rd.idx];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/opentherm_pair_change_monitor.sv @@
// Top level of the OpenTherm pair change monitor: frame checks, pairing, report.
// Depends on opm_pkg and opm_table.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one sniffed frame (tag and
//   data word). Result channel out_valid/out_ready/out_data carries exactly one
//   result per frame, in frame order.
//   A frame is taken in the idle state; the next cycle evaluates it against
//   the pair table word read at the transfer, and the result is registered
//   once evaluation completes. A new frame is taken only after the previous
//   one has finished evaluating, when the sequencer returns to idle.
//   The output register lets a frame be taken while a result waits; if the
//   receiver stalls, evaluation holds until the output register frees up, and
//   no further frame is taken meanwhile.
//   Synchronous reset clears the pairing state, the output valid and all table
//   valid bits at once; no clearing pass is needed, and the first frame may be
//   sent in the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module opentherm_pair_change_monitor (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire opm_pkg::opm_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output opm_pkg::opm_out_t     out_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  opm_pkg::opm_in_t           item_r;
  logic                       expect_slave_r, expect_slave_nxt;
  logic [31:0]                held_master_r, held_master_nxt;
  logic                       out_valid_r, out_valid_nxt;
  opm_pkg::opm_out_t          out_data_r, res;
  opm_pkg::opm_rd_t           rd;
  opm_pkg::opm_wr_t           wr;
  logic [opm_pkg::PAIR_W-1:0] rd_pair;
  logic                       rd_valid;
  logic                       in_xfer, out_free, done;
  logic                       is_master, is_slave;
  logic [31:0]                w;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign done      = (state_r == ST_EVAL) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Read the entry of the held master's id at the transfer
  assign rd.en  = in_xfer;
  assign rd.idx = held_master_r[23:16];

  opm_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd         (rd),
    .wr         (wr),
    .rd_pair_r  (rd_pair),
    .rd_valid_r (rd_valid)
  );

  // Evaluate the captured frame against pairing state and table data
  always_comb begin
    w                = item_r.data_word;
    is_master        = (item_r.frame_tag == opm_pkg::TAG_MASTER);
    is_slave         = (item_r.frame_tag == opm_pkg::TAG_SLAVE);
    res              = '0;
    expect_slave_nxt = expect_slave_r;
    held_master_nxt  = held_master_r;
    wr.en            = 1'b0;
    wr.idx           = held_master_r[23:16];
    wr.pair          = {held_master_r, w};
    if (!is_master && !is_slave) begin
      res.status = opm_pkg::STAT_UNKNOWN;
    end else if (^w) begin
      res.status = opm_pkg::STAT_PARITY;
    end else if (is_master) begin
      if (expect_slave_r) begin
        res.status       = opm_pkg::STAT_ORDER;
        expect_slave_nxt = 1'b0;
      end else begin
        res.status        = opm_pkg::STAT_HELD;
        res.msg_id        = w[23:16];
        res.master_word   = w;
        res.master_type   = w[30:27];
        res.spare_nonzero = |w[26:24];
        held_master_nxt   = w;
        expect_slave_nxt  = 1'b1;
      end
    end else if (!expect_slave_r) begin
      res.status = opm_pkg::STAT_ORDER;
    end else begin
      expect_slave_nxt  = 1'b0;
      res.msg_id        = held_master_r[23:16];
      res.master_word   = held_master_r;
      res.slave_word    = w;
      res.master_type   = held_master_r[30:27];
      res.slave_type    = w[30:27];
      res.spare_nonzero = (|held_master_r[26:24]) || (|w[26:24]);
      if (held_master_r[23:16] != w[23:16]) begin
        res.status = opm_pkg::STAT_MISMATCH;
      end else if (rd_valid && (rd_pair == {held_master_r, w})) begin
        res.status = opm_pkg::STAT_UNCHANGED;
      end else begin
        res.status = opm_pkg::STAT_REPORTED;
        wr.en      = done;
      end
    end
  end

  // Advance the sequencer and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      expect_slave_r <= 1'b0;
      held_master_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (done) begin
        expect_slave_r <= expect_slave_nxt;
        held_master_r  <= held_master_nxt;
      end
    end
  end

  // Capture the frame and hold the result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    if (done) begin
      out_data_r <= res;
    end
  end

  // A transfer always leads into evaluation
  a_xfer_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_EVAL))
    else $error("frame transfer did not start evaluation");

  // Table writes only on a completing evaluation that reports
  a_wr_on_report: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (done && (res.status == opm_pkg::STAT_REPORTED)))
    else $error("table write outside a reported pair");

  // Pairing state moves only when an evaluation completes
  a_pair_state: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(expect_slave_r) |-> $past(done))
    else $error("pairing state changed without a completed frame");

  // A completed evaluation always leaves a result pending
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r)
    else $error("completed frame produced no result");

endmodule

`default_nettype wire

@@ tb/opentherm_pair_change_monitor_tb.sv @@
// Self-checking bench for opentherm_pair_change_monitor: random and directed frames
// are checked against an in-bench pairing model. Depends on opm_pkg and the block.
`timescale 1ns / 1ps

module opentherm_pair_change_monitor_tb;

  localparam int FRAME_TOTAL  = 950;
  localparam int IDLE_PCT     = 34;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_AT      = 700;
  localparam int CALM_LO      = 300;
  localparam int CALM_HI      = 450;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 10;

  typedef struct {
    opm_pkg::opm_in_t frame;
    bit               drain;
  } frame_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  opm_pkg::opm_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  opm_pkg::opm_out_t out_data;

  frame_item_t       frame_backlog[$];
  opm_pkg::opm_out_t frame_verdicts[$];

  // Pairing model state
  logic        slave_due;
  logic [31:0] held_word;
  logic [63:0] pair_store [opm_pkg::TBL_DEPTH];
  logic        pair_seen  [opm_pkg::TBL_DEPTH];

  int sent_n;
  int result_n;
  int mismatch_n;
  int hold_left;
  bit hold_done;
  int quiet_n;

  opentherm_pair_change_monitor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Work out the result of one frame and advance the pairing state
  function automatic opm_pkg::opm_out_t judge_frame(opm_pkg::opm_in_t f);
    opm_pkg::opm_out_t r;
    logic [31:0]       w;
    logic [31:0]       m;
    logic [7:0]        id;
    r = '0;
    w = f.data_word;
    if (f.frame_tag != opm_pkg::TAG_MASTER && f.frame_tag != opm_pkg::TAG_SLAVE) begin
      r.status = opm_pkg::STAT_UNKNOWN;
    end else if (^w) begin
      r.status = opm_pkg::STAT_PARITY;
    end else if (f.frame_tag == opm_pkg::TAG_MASTER) begin
      if (slave_due) begin
        slave_due = 1'b0;
        r.status = opm_pkg::STAT_ORDER;
      end else begin
        held_word = w;
        slave_due = 1'b1;
        r.status = opm_pkg::STAT_HELD;
        r.msg_id = w[23:16];
        r.master_word = w;
        r.master_type = w[30:27];
        r.spare_nonzero = |w[26:24];
      end
    end else if (!slave_due) begin
      r.status = opm_pkg::STAT_ORDER;
    end else begin
      slave_due = 1'b0;
      m = held_word;
      id = m[23:16];
      r.msg_id = id;
      r.master_word = m;
      r.slave_word = w;
      r.master_type = m[30:27];
      r.slave_type = w[30:27];
      r.spare_nonzero = |m[26:24] || |w[26:24];
      if (id != w[23:16]) begin
        r.status = opm_pkg::STAT_MISMATCH;
      end else if (pair_seen[id] && pair_store[id] == {m, w}) begin
        r.status = opm_pkg::STAT_UNCHANGED;
      end else begin
        pair_store[id] = {m, w};
        pair_seen[id] = 1'b1;
        r.status = opm_pkg::STAT_REPORTED;
      end
    end
    return r;
  endfunction

  // Force even parity over the whole word, with the id placed in bits 23..16
  function automatic logic [31:0] make_word(logic [31:0] raw, logic [7:0] id);
    logic [31:0] w;
    w = raw;
    w[23:16] = id;
    w[31] = ^w[30:0];
    return w;
  endfunction

  function automatic logic [31:0] pick_raw();
    logic [31:0] raw;
    raw = $urandom;
    // Draw from a narrow pool half the time so stored pairs come back
    if ($urandom_range(0, 1) == 0) raw = raw & 32'h7F00_0003;
    return raw;
  endfunction

  task automatic push_frame(logic [31:0] tag, logic [31:0] word, bit drain = 1'b0);
    frame_item_t it;
    it.frame.frame_tag = tag;
    it.frame.data_word = word;
    it.drain = drain;
    frame_backlog.push_back(it);
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at result %0d, %s", result_n, what);
    mismatch_n++;
  endtask

  task automatic check_result(opm_pkg::opm_out_t got, opm_pkg::opm_out_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("status: got %h, expected %h", got.status, want.status));
    if (got.msg_id !== want.msg_id)
      report_mismatch($sformatf("msg_id: got %h, expected %h", got.msg_id, want.msg_id));
    if (got.master_word !== want.master_word)
      report_mismatch($sformatf("master_word: got %h, expected %h",
                                got.master_word, want.master_word));
    if (got.slave_word !== want.slave_word)
      report_mismatch($sformatf("slave_word: got %h, expected %h",
                                got.slave_word, want.slave_word));
    if (got.master_type !== want.master_type)
      report_mismatch($sformatf("master_type: got %h, expected %h",
                                got.master_type, want.master_type));
    if (got.slave_type !== want.slave_type)
      report_mismatch($sformatf("slave_type: got %h, expected %h",
                                got.slave_type, want.slave_type));
    if (got.spare_nonzero !== want.spare_nonzero)
      report_mismatch($sformatf("spare_nonzero: got %h, expected %h",
                                got.spare_nonzero, want.spare_nonzero));
  endtask

  // Driver: predict on each input transfer, then offer the next frame
  always @(posedge clk) begin
    frame_item_t nxt;
    bit          calm;
    bit          go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        frame_verdicts.push_back(judge_frame(in_data));
        sent_n++;
      end
      if (!in_valid || in_ready) begin
        calm = (sent_n >= CALM_LO && sent_n < CALM_HI);
        go = frame_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        // Hold a marked frame until every outstanding result has come back
        if (go && frame_backlog[0].drain && frame_verdicts.size() != 0) go = 1'b0;
        if (go) begin
          nxt = frame_backlog.pop_front();
          in_data <= nxt.frame;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then drive the receiver's ready
  always @(posedge clk) begin
    opm_pkg::opm_out_t want;
    bit                calm;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_verdicts.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want = frame_verdicts.pop_front();
          check_result(out_data, want);
        end
        result_n++;
      end
      calm = (result_n >= CALM_LO && result_n < CALM_HI);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && result_n >= HOLD_AT) begin
        // Long back-pressure so the block fills and stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_n = 0;
    end else begin
      quiet_n++;
      if (quiet_n >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_n);
        $display("opentherm_pair_change_monitor_tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] m;
    logic [31:0] s;
    logic [31:0] last_m;
    logic [31:0] last_s;
    logic [7:0]  id;
    bit          have_last;
    bit          drain_mid;
    int          k;

    slave_due = 1'b0;
    held_word = '0;
    foreach (pair_seen[i]) pair_seen[i] = 1'b0;
    sent_n = 0;
    result_n = 0;
    mismatch_n = 0;
    hold_left = 0;
    hold_done = 1'b0;
    quiet_n = 0;
    have_last = 1'b0;
    drain_mid = 1'b0;

    // Directed: unknown tags, including a one-bit miss of the master tag
    push_frame(32'h0000_0000, 32'h0000_0000);
    push_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_frame(opm_pkg::TAG_MASTER ^ 32'h1, 32'h0000_0000);
    // Parity errors on both tags
    push_frame(opm_pkg::TAG_MASTER, 32'h0000_0001);
    push_frame(opm_pkg::TAG_SLAVE, 32'h8000_0000);
    // Slave word with no master held
    push_frame(opm_pkg::TAG_SLAVE, 32'h0000_0000);
    // New pair, the same pair again, then a changed slave word
    push_frame(opm_pkg::TAG_MASTER, 32'h0000_0000);
    push_frame(opm_pkg::TAG_SLAVE, 32'h0000_0000);
    push_frame(opm_pkg::TAG_MASTER, 32'h0000_0000);
    push_frame(opm_pkg::TAG_SLAVE, 32'h0000_0000);
    push_frame(opm_pkg::TAG_MASTER, 32'h0000_0000);
    push_frame(opm_pkg::TAG_SLAVE, make_word(32'h4000_1234, 8'h00));
    // Id mismatch with spare bits and top type, then a master while a slave is due
    push_frame(opm_pkg::TAG_MASTER, make_word(32'h7F00_0000, 8'hFF));
    push_frame(opm_pkg::TAG_SLAVE, make_word(32'h0000_0000, 8'hFE));
    push_frame(opm_pkg::TAG_MASTER, make_word(32'h1000_0000, 8'h80));
    push_frame(opm_pkg::TAG_MASTER, make_word(32'h2000_0000, 8'h80));
    push_frame(opm_pkg::TAG_SLAVE, make_word(32'h2000_0000, 8'h80));
    // All-ones pair at the top id, then repeated
    push_frame(opm_pkg::TAG_MASTER, 32'hFFFF_FFFF);
    push_frame(opm_pkg::TAG_SLAVE, 32'hFFFF_FFFF);
    push_frame(opm_pkg::TAG_MASTER, 32'hFFFF_FFFF);
    push_frame(opm_pkg::TAG_SLAVE, 32'hFFFF_FFFF);
    // Rejected words between master and slave leave the pairing alone
    push_frame(opm_pkg::TAG_MASTER, make_word(32'h0800_5555, 8'h42));
    push_frame(32'h1234_5678, 32'h0000_0000);
    push_frame(opm_pkg::TAG_SLAVE, make_word(32'h0100_0000, 8'h42) ^ 32'h8000_0000);
    push_frame(opm_pkg::TAG_SLAVE, make_word(32'h0100_AAAA, 8'h42));

    // Random part: mostly well-formed pairs, some noise and broken sequences
    while (frame_backlog.size() < FRAME_TOTAL) begin
      k = $urandom_range(0, 99);
      if (k < 30 && have_last) begin
        push_frame(opm_pkg::TAG_MASTER, last_m, !have_last);
        push_frame(opm_pkg::TAG_SLAVE, last_s);
      end else if (k < 78) begin
        id = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        m = make_word(pick_raw(), id);
        s = make_word(pick_raw(), id);
        push_frame(opm_pkg::TAG_MASTER, m,
                   !have_last || (!drain_mid && frame_backlog.size() > 500));
        if (frame_backlog.size() > 500) drain_mid = 1'b1;
        push_frame(opm_pkg::TAG_SLAVE, s);
        last_m = m;
        last_s = s;
        have_last = 1'b1;
      end else if (k < 83) begin
        if ($urandom_range(0, 1)) begin
          push_frame($urandom, $urandom);
        end else begin
          push_frame((k[0] ? opm_pkg::TAG_MASTER : opm_pkg::TAG_SLAVE) ^
                     (32'h1 << $urandom_range(0, 31)),
                     make_word($urandom, 8'($urandom)));
        end
      end else if (k < 88) begin
        push_frame(k[0] ? opm_pkg::TAG_MASTER : opm_pkg::TAG_SLAVE,
                   make_word($urandom, 8'($urandom)) ^ (32'h1 << $urandom_range(0, 31)));
      end else if (k < 91) begin
        push_frame(opm_pkg::TAG_SLAVE, make_word($urandom, 8'($urandom)));
      end else if (k < 94) begin
        push_frame(opm_pkg::TAG_MASTER, make_word($urandom, 8'($urandom)));
        push_frame(opm_pkg::TAG_MASTER, make_word($urandom, 8'($urandom)));
      end else if (k < 97) begin
        id = 8'($urandom);
        push_frame(opm_pkg::TAG_MASTER, make_word($urandom, id));
        push_frame(opm_pkg::TAG_SLAVE,
                   make_word($urandom, id ^ 8'($urandom_range(1, 255))));
      end else begin
        id = 8'($urandom_range(0, 7));
        push_frame(opm_pkg::TAG_MASTER, make_word(pick_raw(), id));
        push_frame($urandom, $urandom);
        push_frame(opm_pkg::TAG_SLAVE, make_word(pick_raw(), id));
      end
    end

    // Reset, then let the driver and monitor run
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (frame_backlog.size() != 0 || in_valid) @(posedge clk);
    while (frame_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (frame_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", frame_verdicts.size()));
    end
    if (mismatch_n == 0) begin
      $display("opentherm_pair_change_monitor_tb passed");
    end else begin
      $display("opentherm_pair_change_monitor_tb failed");
    end
    $finish;
  end

endmodule
